// ----- rtl/core/ckvt_pkg.sv -----
// Package for the compacting key/value table: item structs, opcode and
// status codes, defaults and the command/status structs between controller
// and datapath. No dependencies.
`default_nettype none

package ckvt_pkg;

  // Default geometry
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_VALUE_BITS  = 64;

  // Fixed field widths on the ports
  localparam int IN_KEY_W  = 16;
  localparam int OUT_VAL_W = 64;
  localparam int OUT_CNT_W = 6;

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [IN_KEY_W-1:0]  key;
    logic [OUT_VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] assigned_key;
    logic [OUT_VAL_W-1:0] found_value;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;   // capture the input transaction, restart the read pointer
    logic issue_rd;    // read the entry at the pointer, advance it
    logic take_hit;    // record the matching entry
    logic shift_start; // point the reader just past the matching entry
    logic shift_wr;    // write the last read entry one position down
    logic finish;      // commit the table update and load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lookup;   // opcode is find or remove
    logic remove;   // opcode is remove
    logic hit;      // entry read last cycle matches the key
    logic more;     // pointer still below the entry count
    logic rd_pend;  // a read issued last cycle has data now
    logic found;    // a match has been recorded
    logic out_free; // result register can take a new transaction
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/ckvt_dp.sv -----
// Datapath of the compacting key/value table: entry memory, read pointer,
// entry count and result register. Depends on ckvt_pkg.
`default_nettype none

module ckvt_dp #(
  parameter int TABLE_DEPTH = ckvt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = ckvt_pkg::DEF_VALUE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ckvt_pkg::in_item_t in_data,
  input  wire ckvt_pkg::cmd_t     cmd,
  output ckvt_pkg::sts_t          sts,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output ckvt_pkg::out_item_t     out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = ckvt_pkg::IN_KEY_W;
  localparam int OW = ckvt_pkg::OUT_CNT_W;
  localparam int VW = ckvt_pkg::OUT_VAL_W;

  // Entry memory
  logic [CW-1:0]         key_mem_r [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem_r [TABLE_DEPTH];

  // Captured transaction
  logic [1:0]            op_r;
  logic [KW-1:0]         key_r;
  logic [VALUE_BITS-1:0] val_r;

  // Table and reader state
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ptr_r;
  logic                  rd_vld_r;
  logic [CW-1:0]         rd_idx_r;
  logic [CW-1:0]         rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic                  found_r;
  logic [VALUE_BITS-1:0] fval_r;

  // Result register
  logic                  out_valid_r;
  ckvt_pkg::out_item_t   out_data_r;
  ckvt_pkg::out_item_t   res;

  logic                  full, is_lookup, insert_ok, remove_ok;
  logic [CW-1:0]         shift_idx;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [CW-1:0]         wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic [CW+KW-1:0]      key_ext, req_ext;
  logic [CW+OW-1:0]      cnt_ext;
  logic [VALUE_BITS+VW-1:0] fval_ext;

  // Decode the captured transaction
  assign full      = (count_r >= CW'(TABLE_DEPTH));
  assign is_lookup = (op_r inside {ckvt_pkg::OP_FIND, ckvt_pkg::OP_REMOVE});
  assign insert_ok = (op_r == ckvt_pkg::OP_INSERT) && !full;
  assign remove_ok = (op_r == ckvt_pkg::OP_REMOVE) && found_r;

  // Compare the entry read last cycle against the requested key
  assign key_ext = {{KW{1'b0}}, rd_key_r};
  assign req_ext = {{CW{1'b0}}, key_r};

  assign sts.lookup   = is_lookup;
  assign sts.remove   = (op_r == ckvt_pkg::OP_REMOVE);
  assign sts.hit      = rd_vld_r && (key_ext == req_ext);
  assign sts.more     = (ptr_r < count_r);
  assign sts.rd_pend  = rd_vld_r;
  assign sts.found    = found_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  // Select the memory write: shift-down or append
  assign shift_idx = rd_idx_r - 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_key  = count_r + 1'b1;
    wr_val  = val_r;
    if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = shift_idx[AW-1:0];
      wr_key  = rd_key_r;
      wr_val  = rd_val_r;
    end else if (cmd.finish && insert_ok) begin
      wr_en = 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr] <= wr_key;
      val_mem_r[wr_addr] <= wr_val;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (cmd.issue_rd) begin
      rd_idx_r <= ptr_r;
      rd_key_r <= key_mem_r[ptr_r[AW-1:0]];
      rd_val_r <= val_mem_r[ptr_r[AW-1:0]];
    end
  end

  // Capture the input transaction and the value of the matching entry
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.key;
      val_r <= in_data.value[VALUE_BITS-1:0];
    end
    if (cmd.take_hit) begin
      fval_r <= rd_val_r;
    end
  end

  // Advance the read pointer and track pending reads and the match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.load_item) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue_rd;
      if (cmd.shift_start) begin
        ptr_r <= rd_idx_r + 1'b1;
      end else if (cmd.issue_rd) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.take_hit) begin
        found_r <= 1'b1;
      end
    end
  end

  // Form the result and the new entry count
  always_comb begin
    count_nxt = count_r;
    if (insert_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (remove_ok) begin
      count_nxt = count_r - 1'b1;
    end
    cnt_ext  = {{OW{1'b0}}, count_nxt};
    fval_ext = {{VW{1'b0}}, fval_r};

    res.status       = ckvt_pkg::ST_DONE;
    res.assigned_key = '0;
    res.found_value  = '0;
    res.entry_count  = cnt_ext[OW-1:0];
    if (op_r == ckvt_pkg::OP_INSERT) begin
      if (full) begin
        res.status = ckvt_pkg::ST_FULL;
      end else begin
        res.assigned_key = cnt_ext[OW-1:0];
      end
    end else if (is_lookup) begin
      if (found_r) begin
        res.found_value = fval_ext[VW-1:0];
      end else begin
        res.status = ckvt_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Commit the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A shift write never targets below the first position
  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> (rd_idx_r != '0))
    else $error("shift write from position zero");

  // A finished transaction is presented on the next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result not presented after finish");

endmodule

`default_nettype wire

// ----- rtl/core/ckvt_ctrl.sv -----
// Controller of the compacting key/value table: sequences accept, scan,
// shift and result load over the datapath. Depends on ckvt_pkg.
`default_nettype none

module ckvt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output ckvt_pkg::cmd_t      cmd,
  input  wire ckvt_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.lookup) begin
          state_nxt = S_FINISH;
        end else if (sts.hit) begin
          cmd.take_hit = 1'b1;
          if (sts.remove) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          cmd.issue_rd = sts.more;
          if (!sts.more && !sts.rd_pend) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.issue_rd = sts.more;
        cmd.shift_wr = sts.rd_pend;
        if (!sts.more && !sts.rd_pend) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Reads are only issued below the entry count
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_rd |-> sts.more)
    else $error("read issued past entry count");

  // Shifting only follows a recorded match of a remove
  a_shift_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (sts.found && sts.remove))
    else $error("shift without a matched remove");

  // A result is loaded only into a free result register
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over a waiting result");

endmodule

`default_nettype wire

// ----- rtl/core/compacting_key_value_table_core.sv -----
// Top level of the compacting key/value table: joins the controller and
// the datapath. Depends on ckvt_pkg, ckvt_ctrl and ckvt_dp.
//
// Usage: one transaction on the in_ channel (opcode, key, value) yields
// exactly one transaction on the out_ channel (status, assigned_key,
// found_value, entry_count). A transaction moves on a rising edge where
// valid is high and stall is low; the receiver drives stall.
// Sequence: an insert, or the unused opcode, goes straight to the result
// without a scan. A find reads the entries in order from position 0 until
// one matches; a miss reads every live entry. A remove reads up to its
// match, then moves every later entry one position down. Throughput is one
// transaction at a time, so the rate is set by the single read port of the
// entry memory, one entry a cycle.
// The next transaction is accepted as soon as the block is idle, even while
// a result still waits in the output register; if the receiver stalls, the
// finished result holds there and the block waits before loading the next.
// Reset clears the entry count and the handshake state; entry contents are
// not cleared and need no clearing pass.
`default_nettype none

module compacting_key_value_table_core #(
  parameter int TABLE_DEPTH = ckvt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = ckvt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ckvt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ckvt_pkg::out_item_t      out_data
);

  ckvt_pkg::cmd_t cmd;
  ckvt_pkg::sts_t sts;

  ckvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ckvt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/ckvt_checker.sv -----
// Checker for the compacting key/value table: watches both channels, keeps
// its own copy of the table to predict each result and compares field by
// field. Depends on ckvt_pkg.
module ckvt_checker #(
  parameter int TABLE_DEPTH = ckvt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = ckvt_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ckvt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ckvt_pkg::out_item_t out_data,
  output int                  err_count,
  output int                  pend_count,
  output int                  result_count,
  output int                  full_count,
  output int                  miss_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = ckvt_pkg::OUT_CNT_W;
  localparam int VAL_W = ckvt_pkg::OUT_VAL_W;

  // Shadow table: rows below row_count are live
  logic [15:0]           row_key [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] row_val [TABLE_DEPTH];
  int                    row_count = 0;

  ckvt_pkg::out_item_t answers_q[$];
  int        errs    = 0;
  int        results = 0;
  int        fulls   = 0;
  int        misses  = 0;

  // Apply one operation to the shadow table and return its answer
  function automatic ckvt_pkg::out_item_t run_table_op(input ckvt_pkg::in_item_t item);
    ckvt_pkg::out_item_t res;
    int        hit_pos;
    res        = '0;
    res.status = ckvt_pkg::ST_DONE;
    case (item.opcode)
      ckvt_pkg::OP_INSERT: begin
        if (row_count >= TABLE_DEPTH) begin
          res.status = ckvt_pkg::ST_FULL;
        end else begin
          row_key[row_count] = 16'(row_count + 1);
          row_val[row_count] = item.value[VALUE_BITS-1:0];
          row_count++;
          res.assigned_key = CNT_W'(row_count);
        end
      end
      ckvt_pkg::OP_FIND, ckvt_pkg::OP_REMOVE: begin
        // first matching row wins, duplicates included
        hit_pos = -1;
        for (int i = 0; i < row_count; i++)
          if (hit_pos < 0 && row_key[i] == item.key) hit_pos = i;
        if (hit_pos < 0) begin
          res.status = ckvt_pkg::ST_NOT_FOUND;
        end else begin
          res.found_value = VAL_W'(row_val[hit_pos]);
          if (item.opcode == ckvt_pkg::OP_REMOVE) begin
            // close the gap left by the removed row
            for (int j = hit_pos; j + 1 < row_count; j++) begin
              row_key[j] = row_key[j+1];
              row_val[j] = row_val[j+1];
            end
            row_count--;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(row_count);
    return res;
  endfunction

  // Compare results first, then predict the newly accepted transaction
  always @(posedge clk) begin
    ckvt_pkg::out_item_t want;
    if (!rst_n) begin
      row_count = 0;
      answers_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          errs++;
          $error("unexpected result transaction: %h", out_data);
        end else begin
          want = answers_q.pop_front();
          results++;
          if (want.status == ckvt_pkg::ST_FULL) fulls++;
          if (want.status == ckvt_pkg::ST_NOT_FOUND) misses++;
          if (out_data.status !== want.status) begin
            errs++;
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
          end
          if (out_data.assigned_key !== want.assigned_key) begin
            errs++;
            $error("assigned_key: expected %0d, actual %0d",
                   want.assigned_key, out_data.assigned_key);
          end
          if (out_data.found_value !== want.found_value) begin
            errs++;
            $error("found_value: expected %h, actual %h",
                   want.found_value, out_data.found_value);
          end
          if (out_data.entry_count !== want.entry_count) begin
            errs++;
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_data.entry_count);
          end
        end
      end
      if (in_valid && !in_stall) answers_q.push_back(run_table_op(in_data));
    end
    err_count    <= errs;
    pend_count   <= answers_q.size();
    result_count <= results;
    full_count   <= fulls;
    miss_count   <= misses;
  end

endmodule

// ----- tb/sv/compacting_key_value_table_core_test.sv -----
// Top of the compacting key/value table testbench: clock, reset, stimulus,
// output stall pattern, watchdog and verdict. Depends on ckvt_pkg, the
// block compacting_key_value_table_core and ckvt_checker.
module compacting_key_value_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEMS       = 1550;
  localparam int         HOLD_CYCLES = 400;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         TAIL_CYCLES = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  ckvt_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  ckvt_pkg::out_item_t out_data;

  int err_count;
  int pend_count;
  int result_count;
  int full_count;
  int miss_count;

  int sent_count     = 0;
  int idle_cycles    = 0;
  bit burst_mode     = 1'b0;
  bit long_hold_req  = 1'b0;

  compacting_key_value_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ckvt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .err_count    (err_count),
    .pend_count   (pend_count),
    .result_count (result_count),
    .full_count   (full_count),
    .miss_count   (miss_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none in burst rounds
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Keys mostly near the live range so lookups hit often
  function automatic logic [15:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 34));
    if (r < 95) return 16'($urandom_range(0, 65535));
    if (r < 98) return 16'hFFFF;
    return 16'h0000;
  endfunction

  // Offer one transaction, hold it until accepted, then idle for the requested gap
  task automatic send_item(input logic [1:0] op, input logic [15:0] key,
                           input logic [63:0] val, input int gap);
    ckvt_pkg::in_item_t item;
    item.opcode = op;
    item.key    = key;
    item.value  = val;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED) sent_count++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_table_ops();
    in_valid <= 1'b0;
    do @(posedge clk); while (pend_count != 0);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int mode;
    int len;
    int r;
    int ins_pct;
    int find_pct;
    logic [1:0] op;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, stored zero, extremes, duplicate keys
    send_item(ckvt_pkg::OP_FIND,   16'd0,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd1,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_INSERT, 16'hFFFF,  64'd0,        pick_gap());
    send_item(ckvt_pkg::OP_INSERT, 16'd0,     '1,           pick_gap());
    send_item(ckvt_pkg::OP_INSERT, 16'd7,     64'h0123_4567_89AB_CDEF, pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd1,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd2,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'hFFFF,  rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd40,    rand_value(), pick_gap());
    send_item(OP_UNUSED,           16'hFFFF,  '1,           pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd1,     '1,           pick_gap());
    // this insert hands out key 3 again
    send_item(ckvt_pkg::OP_INSERT, 16'd0,     64'h5555_5555_5555_5555, pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_FIND,   16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd2,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd3,     rand_value(), pick_gap());
    send_item(ckvt_pkg::OP_INSERT, 16'd0,     64'hAAAA_AAAA_AAAA_AAAA, pick_gap());
    send_item(ckvt_pkg::OP_REMOVE, 16'd1,     rand_value(), pick_gap());

    // Fill past full while the receiver holds off
    drain_table_ops();
    long_hold_req = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_item(ckvt_pkg::OP_INSERT, rand_key(), rand_value(), 0);
    end

    // Random rounds, each with its own operation mix
    while (sent_count < ITEMS) begin
      mode       = $urandom_range(0, 2);
      burst_mode = ($urandom_range(0, 3) == 0);
      len        = $urandom_range(30, 80);
      case (mode)
        0:       begin ins_pct = 60; find_pct = 20; end
        1:       begin ins_pct = 34; find_pct = 33; end
        default: begin ins_pct = 20; find_pct = 30; end
      endcase
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          op = OP_UNUSED;
        end else begin
          r = $urandom_range(0, 99);
          if (r < ins_pct) op = ckvt_pkg::OP_INSERT;
          else if (r < ins_pct + find_pct) op = ckvt_pkg::OP_FIND;
          else op = ckvt_pkg::OP_REMOVE;
        end
        send_item(op, rand_key(), rand_value(), pick_gap());
      end
      if ($urandom_range(0, 9) == 0) drain_table_ops();
    end

    drain_table_ops();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d table operations sent, %0d results checked.",
             sent_count, result_count);
    $display("Summary: %0d table-full and %0d key-not-found answers, one %0d-cycle hold-off.",
             full_count, miss_count, HOLD_CYCLES);
    if (err_count == 0 && pend_count == 0)
      $display("[compacting_key_value_table_core] OK");
    else
      $display("[compacting_key_value_table_core] ERROR");
    $finish;
  end

  // Receiver: random stall pattern, plus one long hold-off on request
  initial begin : receiver
    int r;
    int n;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 12);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 96) begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 50);
        end else begin
          out_stall <= 1'b0;
          n = $urandom_range(30, 80);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("[compacting_key_value_table_core] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ckvt_pkg.sv
rtl/core/ckvt_dp.sv
rtl/core/ckvt_ctrl.sv
rtl/core/compacting_key_value_table_core.sv
tb/sv/ckvt_checker.sv
tb/sv/compacting_key_value_table_core_test.sv
